FILE: hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared types and character codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_MUL   = 8'h2A;
	localparam logic [7:0] SYM_DIV   = 8'h2F;
	localparam logic [7:0] SYM_POW   = 8'h5E;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_ZERO = 3'd5
	} op_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [31:0] x;
		logic [31:0] y;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        divzero;
		logic [31:0] result;
	} alu_rsp_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} out_word_t;

endpackage

FILE: hdl/pfe_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// A word channel with valid, ready and a payload of a given type.
// ----------------------------------------------------------------------------
interface pfe_if #(
	parameter type word_t = logic
) (
	input logic clk
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready, input clk);
	modport sink   (input valid, input data, output ready, input clk);
endinterface

FILE: hdl/pfe_alu.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Multi-cycle unit: add, subtract, shift-add multiply, restoring divide and
// square-and-multiply power, one step per cycle.
// ----------------------------------------------------------------------------
module pfe_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::alu_req_t req,
	output pfe_pkg::alu_rsp_t rsp
);
	import pfe_pkg::*;

	typedef enum logic [5:0] {
		A_IDLE = 6'b000001,
		A_MUL  = 6'b000010,
		A_DIV  = 6'b000100,
		A_PSQ  = 6'b001000,
		A_PMUL = 6'b010000,
		A_DONE = 6'b100000
	} astate_t;

	astate_t     state_q;
	logic [31:0] acc_q, mcand_q, mplier_q, base_q, exp_q, res_q, rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        neg_q, dz_q, pow_q;
	logic [32:0] rem_sh;
	logic [31:0] ax, ay;

	assign ax = req.x[31] ? -req.x : req.x;
	assign ay = req.y[31] ? -req.y : req.y;
	assign rem_sh = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			case (state_q)
				A_IDLE: begin
					dz_q <= 1'b0;
					if (req.start) begin
						case (req.op)
							OP_ADD: begin
								res_q <= req.x + req.y;
								state_q <= A_DONE;
							end
							OP_SUB: begin
								res_q <= req.x - req.y;
								state_q <= A_DONE;
							end
							OP_MUL: begin
								acc_q <= '0;
								mcand_q <= req.x;
								mplier_q <= req.y;
								pow_q <= 1'b0;
								cnt_q <= '0;
								state_q <= A_MUL;
							end
							OP_DIV: begin
								if (req.y == '0) begin
									dz_q <= 1'b1;
									res_q <= '0;
									state_q <= A_DONE;
								end else begin
									rem_q <= '0;
									quo_q <= ax;
									dvs_q <= ay;
									neg_q <= req.x[31] ^ req.y[31];
									cnt_q <= '0;
									state_q <= A_DIV;
								end
							end
							OP_POW: begin
								if (req.y[31]) begin
									state_q <= A_DONE;
									if (req.x == 32'd1) begin
										res_q <= 32'd1;
									end else if (req.x == '1) begin
										res_q <= req.y[0] ? '1 : 32'd1;
									end else begin
										res_q <= '0;
										dz_q <= (req.x == '0);
									end
								end else begin
									res_q <= 32'd1;
									base_q <= req.x;
									exp_q <= req.y;
									state_q <= A_PMUL;
								end
							end
							default: begin
								res_q <= '0;
								state_q <= A_DONE;
							end
						endcase
					end
				end
				A_MUL: begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= pow_q ? A_PSQ : A_DONE;
						if (!pow_q) begin
							res_q <= acc_q + (mplier_q[0] ? mcand_q : '0);
						end else begin
							res_q <= res_q;
						end
					end
				end
				A_PMUL: begin
					if (exp_q == '0) begin
						state_q <= A_DONE;
					end else if (exp_q[0]) begin
						acc_q <= '0;
						mcand_q <= res_q;
						mplier_q <= base_q;
						pow_q <= 1'b1;
						cnt_q <= '0;
						neg_q <= 1'b0;
						state_q <= A_MUL;
					end else begin
						acc_q <= '0;
						mcand_q <= base_q;
						mplier_q <= base_q;
						pow_q <= 1'b1;
						cnt_q <= '0;
						neg_q <= 1'b1;
						state_q <= A_MUL;
					end
				end
				A_PSQ: begin
					if (!neg_q) begin
						res_q <= acc_q;
						exp_q <= {exp_q[31:1], 1'b0};
					end else begin
						base_q <= acc_q;
						exp_q <= exp_q >> 1;
					end
					state_q <= A_PMUL;
				end
				A_DIV: begin
					if (rem_sh >= {1'b0, dvs_q}) begin
						rem_q <= 32'(rem_sh - {1'b0, dvs_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= A_DONE;
						pow_q <= 1'b0;
					end
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	logic div_end;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_end <= 1'b0;
		end else begin
			div_end <= (state_q == A_DIV) && (cnt_q == 6'd31);
		end
	end

	always_comb begin
		rsp.done = (state_q == A_DONE);
		rsp.divzero = dz_q;
		if (div_end) begin
			rsp.result = neg_q ? -quo_q : quo_q;
		end else begin
			rsp.result = res_q;
		end
	end
endmodule

FILE: hdl/postfix_expression_evaluator_core.sv
// A digit is pushed directly; + - * / ^ and unknown symbols read two operands,
// run on the arithmetic unit (^ reuses the shift-add multiplier shared with *)
// and write back one result; a word with last set then hands over the result word.
// One word is in work at a time; the shared arithmetic unit sets the rate.
// Reset clears stack count, error and handshake state; stack memory is not
// cleared and is only read below the count.
module postfix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	pfe_if.sink   in_ch,
	pfe_if.source out_ch
);
	import pfe_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RDY  = 7'b0000010,
		S_RDX  = 7'b0000100,
		S_GO   = 7'b0001000,
		S_WAIT = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_q, y_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]  err_q;
	logic [1:0]  status_q;
	logic [7:0]  sym_q;
	logic        last_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [31:0] wr_data;
	alu_req_t    req;
	alu_rsp_t    rsp;
	op_t         op;

	pfe_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		case (sym_q)
			SYM_PLUS:  op = OP_ADD;
			SYM_MINUS: op = OP_SUB;
			SYM_MUL:   op = OP_MUL;
			SYM_DIV:   op = OP_DIV;
			SYM_POW:   op = OP_POW;
			default:   op = OP_ZERO;
		endcase
		req.start = (state_q == S_GO);
		req.op = op;
		req.x = rd_q;
		req.y = y_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = rsp.result;
		rd_addr = cnt_q[AW-1:0] - AW'(1);
		if (state_q == S_IDLE && in_ch.valid && err_q == ST_OK && cnt_q != CW'(STACK_DEPTH)
				&& in_ch.data.symbol >= SYM_ZERO && in_ch.data.symbol <= SYM_NINE) begin
			wr_en = 1'b1;
			wr_data = {24'd0, in_ch.data.symbol - SYM_ZERO};
		end
		if (state_q == S_RDY || state_q == S_RDX) begin
			rd_addr = cnt_q[AW-1:0] - AW'(2);
		end
		if (state_q == S_WAIT && rsp.done && !rsp.divzero) begin
			wr_en = 1'b1;
			wr_addr = cnt_q[AW-1:0] - AW'(2);
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			err_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						sym_q <= in_ch.data.symbol;
						last_q <= in_ch.data.last;
						state_q <= S_FIN;
						if (err_q == ST_OK) begin
							if (in_ch.data.symbol >= SYM_ZERO && in_ch.data.symbol <= SYM_NINE) begin
								if (cnt_q == CW'(STACK_DEPTH)) begin
									err_q <= ST_OVERFLOW;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end else if (cnt_q < CW'(2)) begin
								err_q <= ST_UNDERFLOW;
							end else begin
								state_q <= S_RDY;
							end
						end
					end
				end
				S_RDY: begin
					y_q <= rd_q;
					state_q <= S_RDX;
				end
				S_RDX: begin
					state_q <= S_GO;
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						if (rsp.divzero) begin
							err_q <= ST_DIVZERO;
							cnt_q <= cnt_q - CW'(2);
						end else begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (last_q) begin
						state_q <= S_OUT;
						status_q <= (err_q == ST_OK && cnt_q == '0) ? ST_UNDERFLOW : err_q;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						cnt_q <= '0;
						err_q <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.data.status = status_q;
	assign out_ch.data.value = (status_q == ST_OK) ? rd_q : '0;
endmodule

FILE: hdl/pfe_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the evaluator's channels for handshake and result consistency.
// ----------------------------------------------------------------------------
module pfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic [1:0]  status
);
	import pfe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
		else $error("Result word changed while stalled.");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("Input taken while a result waits.");
	a_err0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> value == '0)
		else $error("Nonzero value with error status.");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Ready right after accepting a word.");
endmodule

bind postfix_expression_evaluator_core pfe_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.value(out_ch.data.value), .status(out_ch.data.status)
);

FILE: tb/sv/tb_postfix_expression_evaluator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Postfix evaluator core testbench
// Feeds directed and random postfix expressions one character word at a time,
// predicts each reported value and status, and checks the result words in order
// under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_core;
	import pfe_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 12000000;

	typedef struct {
		logic [7:0] symbol;
		logic       last;
		logic       drain;
	} char_item_t;

	logic clk;
	logic arst_n;

	pfe_if #(.word_t(in_word_t))  in_ch  (clk);
	pfe_if #(.word_t(out_word_t)) out_ch (clk);

	postfix_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	char_item_t  pend_chars[$];
	out_word_t   expected_reports[$];
	logic [31:0] eval_stack[DEPTH];
	int          eval_count;
	status_t     eval_err;
	int          fail_count;
	int          gap_left;
	int          stall_left;
	int          quiet_tail;
	longint      cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void raise_err(status_t code);
		if (eval_err == ST_OK) begin
			eval_err = code;
		end
	endfunction

	function automatic void push_operand(logic [31:0] v);
		if (eval_count >= DEPTH) begin
			raise_err(ST_OVERFLOW);
		end else begin
			eval_stack[eval_count] = v;
			eval_count++;
		end
	endfunction

	function automatic logic [31:0] int_power(logic [31:0] x, logic [31:0] y);
		logic [31:0] acc;
		logic [31:0] base;
		acc = 32'd1;
		base = x;
		if (y[31]) begin
			if (x == 32'd1) return 32'd1;
			if (x == 32'hFFFF_FFFF) return y[0] ? 32'hFFFF_FFFF : 32'd1;
			if (x == 32'd0) raise_err(ST_DIVZERO);
			return 32'd0;
		end
		for (int i = 0; i < 32; i++) begin
			if (y[i]) acc = acc * base;
			base = base * base;
		end
		return acc;
	endfunction

	function automatic logic [31:0] combine(logic [31:0] x, logic [31:0] y, logic [7:0] s);
		longint q;
		case (s)
			SYM_PLUS:  return x + y;
			SYM_MINUS: return x - y;
			SYM_MUL:   return x * y;
			SYM_DIV: begin
				if (y == 32'd0) begin
					raise_err(ST_DIVZERO);
					return 32'd0;
				end
				q = longint'($signed(x)) / longint'($signed(y));
				return q[31:0];
			end
			SYM_POW:   return int_power(x, y);
			default:   return 32'd0;
		endcase
	endfunction

	function automatic void eval_char(logic [7:0] s, logic last);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] r;
		out_word_t   rep;
		if (eval_err == ST_OK) begin
			if (s >= SYM_ZERO && s <= SYM_NINE) begin
				push_operand(32'(s - SYM_ZERO));
			end else if (eval_count < 2) begin
				raise_err(ST_UNDERFLOW);
			end else begin
				y = eval_stack[eval_count - 1];
				x = eval_stack[eval_count - 2];
				eval_count -= 2;
				r = combine(x, y, s);
				if (eval_err == ST_OK) push_operand(r);
			end
		end
		if (last) begin
			rep.value = 32'd0;
			if (eval_err == ST_OK) begin
				if (eval_count == 0) raise_err(ST_UNDERFLOW);
				else rep.value = eval_stack[eval_count - 1];
			end
			if (eval_err != ST_OK) rep.value = 32'd0;
			rep.status = eval_err;
			expected_reports.push_back(rep);
			eval_count = 0;
			eval_err = ST_OK;
		end
	endfunction

	function automatic void add_char(logic [7:0] s, logic last);
		char_item_t c;
		c.symbol = s;
		c.last = last;
		c.drain = 1'b0;
		pend_chars.push_back(c);
	endfunction

	function automatic void add_expr(string e);
		for (int i = 0; i < e.len(); i++) begin
			add_char(e[i], i == e.len() - 1);
		end
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 5))
			0: return SYM_PLUS;
			1: return SYM_MINUS;
			2: return SYM_MUL;
			3: return SYM_DIV;
			4: return SYM_POW;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_random_expr();
		int          len;
		int          depth;
		logic        prev_digit;
		logic [7:0]  s;
		len = $urandom_range(1, 14);
		depth = 0;
		prev_digit = 1'b0;
		for (int i = 0; i < len; i++) begin
			if (depth < 2 || $urandom_range(0, 1) == 0) begin
				s = SYM_ZERO + 8'($urandom_range(0, 9));
				depth++;
				prev_digit = 1'b1;
			end else begin
				s = pick_op();
				// Keep exponents small so a power stays cheap.
				if (s == SYM_POW && !prev_digit) s = SYM_MUL;
				depth--;
				prev_digit = 1'b0;
			end
			add_char(s, i == len - 1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				eval_char(in_ch.data.symbol, in_ch.data.last);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					in_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pend_chars.size() > 0 && pend_chars[0].drain) begin
					in_ch.valid <= 1'b0;
					if (expected_reports.size() == 0 && !(in_ch.valid && in_ch.data.last)) begin
						void'(pend_chars.pop_front());
					end
				end else if (pend_chars.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data.symbol <= pend_chars[0].symbol;
					in_ch.data.last <= pend_chars[0].last;
					void'(pend_chars.pop_front());
					if (pend_chars.size() > quiet_tail && $urandom_range(0, 7) == 0) begin
						gap_left <= $urandom_range(1, 3);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (pend_chars.size() > quiet_tail && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_ch.ready <= 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected word value=%0d status=%0d", $time,
						$signed(out_ch.data.value), out_ch.data.status);
					fail_count++;
				end else begin
					if (out_ch.data.value !== expected_reports[0].value) begin
						$display("%0t: value mismatch expected=%0d actual=%0d", $time,
							$signed(expected_reports[0].value), $signed(out_ch.data.value));
						fail_count++;
					end
					if (out_ch.data.status !== expected_reports[0].status) begin
						$display("%0t: status mismatch expected=%0d actual=%0d", $time,
							expected_reports[0].status, out_ch.data.status);
						fail_count++;
					end
					void'(expected_reports.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		char_item_t d;
		string      ovf;
		arst_n = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		eval_count = 0;
		eval_err = ST_OK;
		quiet_tail = 150;

		add_expr("12+");
		add_expr("93-");
		add_expr("78*");
		add_expr("92/");
		add_expr("23^");
		add_expr("00^");
		add_expr("45?");
		add_expr("+");
		add_expr("50/");
		add_expr("101-^");
		add_expr("01-01-^");
		add_expr("01-02-^");
		add_expr("001-^");
		add_expr("201-^");
		add_expr("284*1-^01-/");
		add_expr("50/3+");
		add_expr("123");
		add_expr("7");
		add_expr("0");
		add_expr("9");
		add_char(8'hFF, 1'b1);
		add_char(8'h00, 1'b1);
		ovf = "";
		for (int i = 0; i <= DEPTH; i++) ovf = {ovf, "1"};
		add_expr({ovf, "+"});

		d.symbol = '0;
		d.last = 1'b0;
		d.drain = 1'b1;
		pend_chars.push_back(d);

		while (pend_chars.size() < 1150) begin
			if ($urandom_range(0, 9) == 0) begin
				add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				add_random_expr();
			end
			if (pend_chars.size() > 500 && pend_chars.size() < 520) begin
				pend_chars.push_back(d);
			end
		end
		add_expr("1");

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pend_chars.size() == 0 && !in_ch.valid && expected_reports.size() == 0);
		repeat (3000) @(posedge clk);
		if (fail_count == 0 && expected_reports.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
